@@ hdl/qwmi_pkg.sv @@
package qwmi_pkg;

  localparam int unsigned Depth = 256;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_TAIL   = 2'd0,
    OP_MIDDLE = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic            ins;
    logic            pop;
    logic [CntW-1:0] pos;
    logic [KeyW-1:0] key;
  } cell_cmd_t;

endpackage

@@ hdl/qwmi_cell.sv @@
module qwmi_cell (
  input  logic                            clk_i,
  input  logic [qwmi_pkg::CntW-1:0]       idx_i,
  input  qwmi_pkg::cell_cmd_t             cmd_i,
  input  logic [qwmi_pkg::KeyW-1:0]       prev_i,
  input  logic [qwmi_pkg::KeyW-1:0]       next_i,
  output logic [qwmi_pkg::KeyW-1:0]       data_o
);

  logic [qwmi_pkg::KeyW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.pos) begin
        data_d = cmd_i.key;
      end else if (idx_i > cmd_i.pos) begin
        data_d = prev_i;
      end
    end else if (cmd_i.pop) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hdl/qwmi_ctrl.sv @@
module qwmi_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [qwmi_pkg::KeyW-1:0]     key_i,
  input  logic [qwmi_pkg::KeyW-1:0]     front_i,
  output qwmi_pkg::cell_cmd_t           cmd_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qwmi_pkg::KeyW-1:0]     popped_key_o,
  output logic [1:0]                    status_o,
  output logic [qwmi_pkg::CntW-1:0]     occupancy_o
);

  logic                          accept;
  logic                          full, empty;
  logic                          ins_en, pop_en;
  logic [qwmi_pkg::CntW:0]       count_inc;
  logic [qwmi_pkg::CntW-1:0]     pos;
  qwmi_pkg::status_e             status;
  logic [qwmi_pkg::CntW-1:0]     count_d, count_q;
  logic                          vld_d, vld_q;
  logic [qwmi_pkg::KeyW-1:0]     key_d, key_q;
  qwmi_pkg::status_e             status_d, status_q;
  logic [qwmi_pkg::CntW-1:0]     occ_q;

  assign in_ready_o = !vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == qwmi_pkg::CntW'(qwmi_pkg::Depth));
  assign empty      = (count_q == '0);
  assign count_inc  = {1'b0, count_q} + 1'b1;

  always_comb begin
    ins_en = 1'b0;
    pop_en = 1'b0;
    pos    = count_q;
    status = qwmi_pkg::ST_OK;
    unique case (qwmi_pkg::op_e'(op_i))
      qwmi_pkg::OP_TAIL: begin
        ins_en = !full;
        status = full ? qwmi_pkg::ST_FULL : qwmi_pkg::ST_OK;
      end
      qwmi_pkg::OP_MIDDLE: begin
        ins_en = !full;
        pos    = count_inc[qwmi_pkg::CntW:1];
        status = full ? qwmi_pkg::ST_FULL : qwmi_pkg::ST_OK;
      end
      qwmi_pkg::OP_POP: begin
        pop_en = !empty;
        status = empty ? qwmi_pkg::ST_EMPTY : qwmi_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  assign cmd_o.ins = accept && ins_en;
  assign cmd_o.pop = accept && pop_en;
  assign cmd_o.pos = pos;
  assign cmd_o.key = key_i;

  always_comb begin
    count_d = count_q;
    if (cmd_o.ins) begin
      count_d = count_inc[qwmi_pkg::CntW-1:0];
    end else if (cmd_o.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  assign vld_d    = accept || (vld_q && !out_ready_i);
  assign key_d    = pop_en ? front_i : '0;
  assign status_d = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= key_d;
      status_q <= status_d;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o  = vld_q;
  assign popped_key_o = key_q;
  assign status_o     = status_q;
  assign occupancy_o  = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qwmi_pkg::CntW'(qwmi_pkg::Depth))
    else $error("entry count above depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not shrink the count");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_o.ins && !cmd_o.pop |=> $stable(count_q))
    else $error("count moved without an operation");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status == qwmi_pkg::ST_EMPTY |=> occ_q == '0 && key_q == '0)
    else $error("empty pop result not clean");

endmodule

@@ hdl/queue_with_middle_insertion.sv @@
// Ordered queue of up to 256 signed 32-bit keys held in a row of shifting cells. Each input
// beat carries an op in tuser (0 push at tail, 1 push at middle index (n+1)/2, 2 pop front)
// and a key in tdata, and yields exactly one output beat in the next cycle with the popped key,
// the new occupancy and a status (0 ok, 1 pop on empty, 2 push on full, the key dropped).
// One beat is taken every cycle: every cell chooses hold, its neighbor or the new key in a
// single pass, and the result register keeps taking beats as long as the output side drains
// it. After reset the queue is empty; no clearing pass is needed.
module queue_with_middle_insertion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // key[31:0]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // popped_key[31:0], occupancy[40:32], zero pad
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  qwmi_pkg::cell_cmd_t           cmd;
  logic [qwmi_pkg::KeyW-1:0]     cell_data [qwmi_pkg::Depth];
  logic [qwmi_pkg::KeyW-1:0]     popped_key;
  logic [qwmi_pkg::CntW-1:0]     occupancy;

  qwmi_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .key_i        (s_axis_tdata),
    .front_i      (cell_data[0]),
    .cmd_o        (cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .popped_key_o (popped_key),
    .status_o     (m_axis_tuser),
    .occupancy_o  (occupancy)
  );

  for (genvar g = 0; g < qwmi_pkg::Depth; g++) begin : g_cell
    logic [qwmi_pkg::KeyW-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_prev
      assign prev = cell_data[g-1];
    end
    if (g == qwmi_pkg::Depth - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_next
      assign next = cell_data[g+1];
    end
    qwmi_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (qwmi_pkg::CntW'(g)),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .data_o (cell_data[g])
    );
  end

  assign m_axis_tdata = {7'd0, occupancy, popped_key};

endmodule
